// ===== sv/lru_mc_pkg.sv =====
// Shared types and constants for the LRU miss counter.
// No dependencies; every other file of the block but lru_mc_ram refers to it by scoped names.
package lru_mc_pkg;

  localparam int CFG_W   = 4;
  localparam int COUNT_W = 16;

  localparam logic [CFG_W-1:0]   CACHE_SIZE_RST = 4'd8;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = 16'hFFFF;

  // Largest number of entries the size register can ever select.
  localparam int SIZE_MAX = (1 << CFG_W) - 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } lru_mc_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic start;
    logic scan;
    logic update;
  } lru_mc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } lru_mc_sts_t;

endpackage

// ===== sv/lru_mc_ifs.sv =====
// Handshake channel interfaces: page request, result and size register write.
// Depends on lru_mc_pkg for the fixed field widths.
interface lru_mc_req_if #(
  parameter int PAGE_BITS = 8
);
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page;
  logic                 last_request;

  modport source (output valid, output page, output last_request, input ready);
  modport sink   (input valid, input page, input last_request, output ready);
endinterface

interface lru_mc_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic [lru_mc_pkg::COUNT_W-1:0]    miss_count;
  logic                              list_done;

  modport source (output valid, output hit, output miss_count, output list_done, input ready);
  modport sink   (input valid, input hit, input miss_count, input list_done, output ready);
endinterface

interface lru_mc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lru_mc_pkg::CFG_W-1:0]  cache_size;

  modport source (output valid, output cache_size, input ready);
  modport sink   (input valid, input cache_size, output ready);
endinterface

// ===== sv/lru_miss_counter_core.sv =====
// LRU miss counter: top level joining the sequencer and the datapath.
// Depends on lru_mc_pkg, the channel interfaces, lru_mc_ctrl and lru_mc_dp.
//
// Fully associative cache of page numbers with least-recently-used
// replacement. Each request returns whether its page hit and the running,
// saturating miss count of the current list; a request marked last clears
// the cache and the count after its result. The size register selects how
// many entries are in use (0 acts as 1, values above WAYS as WAYS, and at
// most 15 entries are ever reachable). One request is worked on at a time:
// the entries are scanned one per cycle through the tag RAM's single read
// port, and the next request is accepted only once the last one is updated.
// A result waiting in the output register does not hold up the next
// request's scan.
module lru_miss_counter_core #(
  parameter int WAYS      = 8,
  parameter int PAGE_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  lru_mc_req_if.sink         req_i,
  lru_mc_rsp_if.source       rsp_o,
  lru_mc_cfg_if.sink         cfg_i
);

  lru_mc_pkg::lru_mc_cmd_t cmd;
  lru_mc_pkg::lru_mc_sts_t sts;

  // Size writes must arrive only while idle; the block does not enforce this. Take them at once.
  assign cfg_i.ready = 1'b1;

  lru_mc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lru_mc_dp #(
    .WAYS      (WAYS),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .page_i           (req_i.page),
    .last_request_i   (req_i.last_request),
    .cfg_valid_i      (cfg_i.valid),
    .cfg_cache_size_i (cfg_i.cache_size),
    .out_valid_o      (rsp_o.valid),
    .out_ready_i      (rsp_o.ready),
    .out_hit_o        (rsp_o.hit),
    .out_miss_count_o (rsp_o.miss_count),
    .out_list_done_o  (rsp_o.list_done)
  );

endmodule

// ===== sv/lru_mc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lru_mc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/lru_mc_ctrl.sv =====
// Sequencer for the LRU miss counter: accept, scan the entries, update.
// Depends on lru_mc_pkg for the state enum and the command/status structs.
module lru_mc_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  lru_mc_pkg::lru_mc_sts_t sts_i,
  output lru_mc_pkg::lru_mc_cmd_t cmd_o
);

  lru_mc_pkg::lru_mc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lru_mc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    case (state_q)
      lru_mc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = lru_mc_pkg::ST_SCAN;
        end
      end
      lru_mc_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = lru_mc_pkg::ST_UPDATE;
        end
      end
      lru_mc_pkg::ST_UPDATE: begin
        // hold until the result register can take the new result
        if (sts_i.out_free) begin
          cmd_o.update = 1'b1;
          state_d      = lru_mc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lru_mc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/lru_mc_dp.sv =====
// Datapath: size register, entry tags in RAM, valid and age flops, scan
// accumulators, miss counter and result register.
// Depends on lru_mc_pkg and lru_mc_ram.
module lru_mc_dp #(
  parameter int WAYS      = 8,
  parameter int PAGE_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lru_mc_pkg::lru_mc_cmd_t             cmd_i,
  output lru_mc_pkg::lru_mc_sts_t             sts_o,
  input  logic [PAGE_BITS-1:0]                page_i,
  input  logic                                last_request_i,
  input  logic                                cfg_valid_i,
  input  logic [lru_mc_pkg::CFG_W-1:0]        cfg_cache_size_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                out_hit_o,
  output logic [lru_mc_pkg::COUNT_W-1:0]      out_miss_count_o,
  output logic                                out_list_done_o
);

  // Entries beyond what the size register can reach are never used.
  localparam int USED  = (WAYS < lru_mc_pkg::SIZE_MAX) ? WAYS : lru_mc_pkg::SIZE_MAX;
  localparam int IDX_W = (USED > 1) ? $clog2(USED) : 1;
  localparam int AGE_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAYS - 1);

  logic [lru_mc_pkg::CFG_W-1:0]   cache_size_q;
  logic [PAGE_BITS-1:0]           page_q;
  logic                           last_q;
  logic [IDX_W-1:0]               last_idx;
  logic [USED-1:0]                in_range;

  logic [USED-1:0]                valid_q, valid_d;
  logic [AGE_W-1:0]               age_q [USED];
  logic [AGE_W-1:0]               age_d [USED];

  logic [IDX_W-1:0]               cnt_q;
  logic                           issue_q;
  logic [IDX_W-1:0]               chk_idx_q;
  logic                           chk_v_q;
  logic [PAGE_BITS-1:0]           rdata;
  logic                           chk_valid;
  logic [AGE_W-1:0]               chk_age;

  logic                           found_q;
  logic [IDX_W-1:0]               found_idx_q;
  logic [AGE_W-1:0]               found_age_q;
  logic                           free_v_q;
  logic [IDX_W-1:0]               free_idx_q;
  logic [AGE_W-1:0]               best_q;
  logic [IDX_W-1:0]               vict_q;
  logic [IDX_W-1:0]               slot;

  logic [lru_mc_pkg::COUNT_W-1:0] miss_total_q;
  logic [lru_mc_pkg::COUNT_W-1:0] miss_next;
  logic                           out_valid_q;
  logic                           hit_q;
  logic [lru_mc_pkg::COUNT_W-1:0] miss_count_q;
  logic                           list_done_q;

  // Size register: zero acts as one entry, anything above the ways as all ways.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_size_q <= lru_mc_pkg::CACHE_SIZE_RST;
    end else if (cfg_valid_i) begin
      cache_size_q <= cfg_cache_size_i;
    end
  end

  always_comb begin
    if (cache_size_q == '0) begin
      last_idx = '0;
    end else if (int'(cache_size_q) > USED) begin
      last_idx = IDX_W'(USED - 1);
    end else begin
      last_idx = IDX_W'(cache_size_q - 1'b1);
    end
  end

  for (genvar g = 0; g < USED; g++) begin : g_range
    assign in_range[g] = (IDX_W'(g) <= last_idx);
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      page_q <= page_i;
      last_q <= last_request_i;
    end
  end

  // Tag store: read one entry a cycle during the scan, write the filled slot.
  lru_mc_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (USED)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update & ~found_q),
    .waddr_i (slot),
    .wdata_i (page_q),
    .raddr_i (cnt_q),
    .rdata_o (rdata)
  );

  // Scan pipeline: issue an address, check the entry in the following cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      issue_q   <= 1'b0;
      chk_idx_q <= '0;
      chk_v_q   <= 1'b0;
    end else if (cmd_i.start) begin
      cnt_q   <= '0;
      issue_q <= 1'b1;
      chk_v_q <= 1'b0;
    end else if (cmd_i.scan) begin
      chk_idx_q <= cnt_q;
      chk_v_q   <= issue_q;
      if (issue_q) begin
        if (cnt_q == last_idx) begin
          issue_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  assign chk_valid = valid_q[chk_idx_q];
  assign chk_age   = age_q[chk_idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      found_idx_q <= '0;
      found_age_q <= '0;
      free_v_q    <= 1'b0;
      free_idx_q  <= '0;
      best_q      <= '0;
      vict_q      <= '0;
    end else if (cmd_i.start) begin
      found_q  <= 1'b0;
      free_v_q <= 1'b0;
      best_q   <= '0;
      vict_q   <= '0;
    end else if (cmd_i.scan && chk_v_q) begin
      if (chk_valid) begin
        if (!found_q && rdata == page_q) begin
          found_q     <= 1'b1;
          found_idx_q <= chk_idx_q;
          found_age_q <= chk_age;
        end
      end else if (!free_v_q) begin
        free_v_q   <= 1'b1;
        free_idx_q <= chk_idx_q;
      end
      // strict compare keeps the lowest-numbered entry among equal ages
      if (chk_age > best_q) begin
        best_q <= chk_age;
        vict_q <= chk_idx_q;
      end
    end
  end

  assign slot = free_v_q ? free_idx_q : vict_q;

  assign miss_next = (miss_total_q == lru_mc_pkg::COUNT_MAX) ? miss_total_q
                                                             : miss_total_q + 1'b1;

  // Entry state update, every entry in parallel.
  always_comb begin
    for (int i = 0; i < USED; i++) begin
      valid_d[i] = valid_q[i];
      age_d[i]   = age_q[i];
      if (in_range[i]) begin
        if (found_q) begin
          if (valid_q[i] && age_q[i] < found_age_q) begin
            age_d[i] = age_q[i] + 1'b1;
          end
          if (IDX_W'(i) == found_idx_q) begin
            age_d[i] = '0;
          end
        end else begin
          if (valid_q[i] && age_q[i] < AGE_MAX) begin
            age_d[i] = age_q[i] + 1'b1;
          end
          if (IDX_W'(i) == slot) begin
            valid_d[i] = 1'b1;
            age_d[i]   = '0;
          end
        end
      end
      // drop the whole list once its final request is answered
      if (last_q) begin
        valid_d[i] = 1'b0;
        age_d[i]   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      miss_total_q <= '0;
      for (int i = 0; i < USED; i++) begin
        age_q[i] <= '0;
      end
    end else if (cmd_i.update) begin
      valid_q <= valid_d;
      for (int i = 0; i < USED; i++) begin
        age_q[i] <= age_d[i];
      end
      if (last_q) begin
        miss_total_q <= '0;
      end else if (!found_q) begin
        miss_total_q <= miss_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.update) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      hit_q        <= found_q;
      miss_count_q <= found_q ? miss_total_q : miss_next;
      list_done_q  <= last_q;
    end
  end

  assign sts_o.scan_done = chk_v_q & (chk_idx_q == last_idx);
  assign sts_o.out_free  = ~out_valid_q | out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign out_hit_o        = hit_q;
  assign out_miss_count_o = miss_count_q;
  assign out_list_done_o  = list_done_q;

endmodule

// ===== sim/lru_mc_checker.sv =====
// Checker for the LRU miss counter: watches the request, result and size channels,
// predicts every result from its own copy of the cache and compares in order.
// Depends on lru_mc_pkg and the channel interfaces in lru_mc_ifs.sv.
module lru_mc_checker #(
  parameter int WAYS      = 8,
  parameter int PAGE_BITS = 8
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  lru_mc_req_if  req_i,
  lru_mc_rsp_if  rsp_i,
  lru_mc_cfg_if  cfg_i,
  output int     pending_o,
  output int     errors_o
);

  localparam int AGE_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [AGE_W-1:0] AGE_TOP = AGE_W'(WAYS - 1);

  typedef struct packed {
    logic                           hit;
    logic [lru_mc_pkg::COUNT_W-1:0] miss_count;
    logic                           list_done;
  } lru_result_t;

  logic [PAGE_BITS-1:0]           tag_q   [WAYS];
  logic                           valid_q [WAYS];
  logic [AGE_W-1:0]               age_q   [WAYS];
  logic [lru_mc_pkg::COUNT_W-1:0] misses_q;
  logic [lru_mc_pkg::CFG_W-1:0]   size_q;

  lru_result_t results_due [$];
  lru_result_t want;
  lru_result_t got;
  int          err_cnt;

  function automatic void clear_list();
    for (int i = 0; i < WAYS; i++) begin
      valid_q[i] = 1'b0;
      age_q[i]   = '0;
    end
    misses_q = '0;
  endfunction

  // Look the page up, update recency and the miss count, and return the result.
  function automatic lru_result_t lookup_page(logic [PAGE_BITS-1:0] pg, logic lst);
    int          n;
    int          found;
    int          free_slot;
    int          slot;
    logic [AGE_W-1:0] a;
    logic [AGE_W-1:0] best;
    lru_result_t r;
    n = (size_q == '0) ? 1 : ((int'(size_q) > WAYS) ? WAYS : int'(size_q));
    found     = -1;
    free_slot = -1;
    for (int i = 0; i < n; i++) begin
      if (valid_q[i]) begin
        if (found < 0 && tag_q[i] == pg) found = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (found >= 0) begin
      a = age_q[found];
      for (int i = 0; i < n; i++)
        if (valid_q[i] && age_q[i] < a) age_q[i]++;
      age_q[found] = '0;
      r.hit = 1'b1;
    end else begin
      if (free_slot >= 0) begin
        slot = free_slot;
      end else begin
        // Ties go to the lowest-numbered entry.
        best = '0;
        slot = 0;
        for (int i = 0; i < n; i++)
          if (age_q[i] > best) begin
            best = age_q[i];
            slot = i;
          end
      end
      for (int i = 0; i < n; i++)
        if (valid_q[i] && age_q[i] < AGE_TOP) age_q[i]++;
      tag_q[slot]   = pg;
      valid_q[slot] = 1'b1;
      age_q[slot]   = '0;
      if (misses_q != lru_mc_pkg::COUNT_MAX) misses_q++;
      r.hit = 1'b0;
    end
    r.miss_count = misses_q;
    r.list_done  = lst;
    if (lst) clear_list();
    return r;
  endfunction

  function automatic void flag_mismatch(string field, logic [31:0] exp_v, logic [31:0] act_v);
    err_cnt++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_list();
      size_q = lru_mc_pkg::CACHE_SIZE_RST;
      results_due.delete();
      err_cnt = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) size_q = cfg_i.cache_size;
      if (rsp_i.valid && rsp_i.ready) begin
        got = '{rsp_i.hit, rsp_i.miss_count, rsp_i.list_done};
        if (results_due.size() == 0) begin
          err_cnt++;
          $display("%0t: result with no request outstanding, expected none, got %0b/%0d/%0b",
                   $time, got.hit, got.miss_count, got.list_done);
        end else begin
          want = results_due.pop_front();
          if (got.hit !== want.hit) flag_mismatch("hit", 32'(want.hit), 32'(got.hit));
          if (got.miss_count !== want.miss_count)
            flag_mismatch("miss_count", 32'(want.miss_count), 32'(got.miss_count));
          if (got.list_done !== want.list_done)
            flag_mismatch("list_done", 32'(want.list_done), 32'(got.list_done));
        end
      end
      if (req_i.valid && req_i.ready)
        results_due.push_back(lookup_page(req_i.page, req_i.last_request));
      pending_o <= results_due.size();
      errors_o  <= err_cnt;
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for lru_miss_counter_core: clock, reset, request and size stimulus,
// result back-pressure and the verdict. Checking is done by lru_mc_checker.
// Depends on lru_mc_pkg, lru_mc_ifs.sv, lru_mc_checker and the block itself.
module tb_top;

  localparam int WAYS       = 8;
  localparam int PAGE_BITS  = 8;
  localparam int CFG_W      = lru_mc_pkg::CFG_W;
  localparam int RND_ITEMS  = 1300;
  localparam int SAT_ITEMS  = 100;
  localparam int HOLD_CYC   = 400;
  localparam int LIMIT      = 2_000_000;

  logic clk_i;
  logic rst_ni;
  int   due_cnt;
  int   fail_cnt;
  bit   req_idle;
  bit   rsp_idle;
  int   hold_asked;

  lru_mc_req_if #(.PAGE_BITS(PAGE_BITS)) req_if ();
  lru_mc_rsp_if                          rsp_if ();
  lru_mc_cfg_if                          cfg_if ();

  lru_miss_counter_core #(
    .WAYS     (WAYS),
    .PAGE_BITS(PAGE_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  lru_mc_checker #(
    .WAYS     (WAYS),
    .PAGE_BITS(PAGE_BITS)
  ) checker_i (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_if),
    .rsp_i    (rsp_if),
    .cfg_i    (cfg_if),
    .pending_o(due_cnt),
    .errors_o (fail_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one request and hold it until the block takes it.
  task automatic push_request(input logic [PAGE_BITS-1:0] pg, input logic lst);
    int gap;
    gap = req_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.page         <= pg;
    req_if.last_request <= lst;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
  endtask

  // Drain all outstanding results, let the update pass retire, then write the size.
  task automatic write_size(input logic [CFG_W-1:0] sz);
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (due_cnt != 0);
    repeat (WAYS + 4) @(posedge clk_i);
    cfg_if.valid      <= 1'b1;
    cfg_if.cache_size <= sz;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
  endtask

  // Result side: random stalls, plus a long hold-off when asked.
  initial begin
    int stall;
    int hold_done;
    hold_done = 0;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_done != hold_asked) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk_i);
        hold_done++;
      end
      stall = rsp_idle ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (rsp_if.valid !== 1'b1);
    end
  end

  initial begin
    int               rnd_items;
    int               phase;
    int               phase_len;
    int               list_left;
    int               span;
    logic [PAGE_BITS-1:0] base;
    logic [PAGE_BITS-1:0] pg;
    logic [CFG_W-1:0] sz;

    req_idle   = 1'b1;
    rsp_idle   = 1'b1;
    hold_asked = 0;
    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.page         <= '0;
    req_if.last_request <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.cache_size   <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full cache: hits, fill, then evictions of the least recently used page.
    write_size(4'd8);
    push_request(8'h00, 1'b0);
    push_request(8'hFF, 1'b0);
    push_request(8'h00, 1'b0);
    push_request(8'hFF, 1'b0);
    for (int p = 1; p <= 6; p++) push_request(PAGE_BITS'(p), 1'b0);
    push_request(8'h07, 1'b0);
    push_request(8'h00, 1'b0);
    push_request(8'hFF, 1'b1);

    // Size zero behaves as a single entry.
    write_size(4'd0);
    push_request(8'h03, 1'b0);
    push_request(8'h03, 1'b0);
    push_request(8'h04, 1'b0);
    push_request(8'h03, 1'b1);

    // Size above the number of ways is clamped.
    write_size(4'd15);
    push_request(8'hAA, 1'b0);
    push_request(8'h55, 1'b0);
    push_request(8'hAA, 1'b1);

    // Shrink and regrow with the list still open; the upper entry survives.
    write_size(4'd3);
    push_request(8'h0A, 1'b0);
    push_request(8'h0B, 1'b0);
    push_request(8'h0C, 1'b0);
    write_size(4'd1);
    push_request(8'h0B, 1'b0);
    write_size(4'd3);
    push_request(8'h0C, 1'b1);

    // One long all-miss list on a single entry, back to back.
    write_size(4'd1);
    req_idle = 1'b0;
    rsp_idle = 1'b0;
    for (int k = 0; k < SAT_ITEMS; k++)
      push_request(k[0] ? 8'hFF : 8'h00, k == SAT_ITEMS - 1);

    // Random lists over small page pools, sizes changing between phases.
    rnd_items = 0;
    phase     = 0;
    list_left = 0;
    base      = '0;
    span      = 0;
    while (rnd_items < RND_ITEMS) begin
      case (phase)
        0: begin
          sz = 4'd1;
        end
        1: begin
          sz = 4'd8;
        end
        2: begin
          sz = 4'd0;
        end
        3: begin
          sz = 4'd15;
        end
        default: begin
          sz = CFG_W'($urandom_range(0, 15));
        end
      endcase
      write_size(sz);
      req_idle = ($urandom_range(0, 3) != 0);
      rsp_idle = ($urandom_range(0, 3) != 0);
      if (phase == 2) begin
        // Keep offering requests while the result side holds off.
        req_idle = 1'b0;
        hold_asked++;
      end
      phase_len = $urandom_range(30, 120);
      repeat (phase_len) begin
        if (list_left == 0) begin
          list_left = $urandom_range(1, 40);
          base      = PAGE_BITS'($urandom_range(0, 255));
          span      = $urandom_range(0, 11);
        end
        if ($urandom_range(0, 9) == 0)
          pg = PAGE_BITS'($urandom_range(0, 255));
        else
          pg = PAGE_BITS'(base + $urandom_range(0, span));
        list_left--;
        push_request(pg, list_left == 0);
        rnd_items++;
      end
      phase++;
    end

    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (due_cnt != 0);
    repeat (2 * WAYS + 8) @(posedge clk_i);
    if (fail_cnt == 0 && due_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
